[rtl/core/bhl_pkg.sv]
// ----------------------------------------------------------------------------
// bhl_pkg
// Shared constants, request codes and the cell command struct of the
// bounded handle list.
// ----------------------------------------------------------------------------
package bhl_pkg;

    // Number of cells in the list
    localparam int DEPTH  = 16;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 64;
    localparam int CAP_W  = 5;
    localparam int FLD_W  = 4;

    // Common width for comparing counts, indexes and the capacity
    localparam int CMP_W_A = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int CMP_W   = (CMP_W_A > FLD_W) ? CMP_W_A : FLD_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // Request codes
    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_SWAP   = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;
    localparam logic [1:0] REQ_GET    = 2'd3;

    // Register port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_CAPACITY = 1'b0;

    // Command broadcast from the controller to every cell
    typedef struct packed {
        logic              load;     // copy entry into the read chain
        logic              shift;    // move the read chain one cell toward cell 0
        logic              wr_add;   // append add_val at index count
        logic              wr_swap;  // exchange entries at idx_a and idx_b
        logic              wr_rm;    // close the gap at idx_a
        logic [CMP_W-1:0]  idx_a;
        logic [CMP_W-1:0]  idx_b;
        logic [CMP_W-1:0]  count;
        logic [DATA_W-1:0] val_a;
        logic [DATA_W-1:0] val_b;
        logic [DATA_W-1:0] add_val;
    } bhl_cmd_t;

endpackage

[rtl/core/bhl_cell.sv]
// ----------------------------------------------------------------------------
// bhl_cell
// One list slot: holds one handle and one stage of the read chain, and
// updates both from the broadcast command and its upper neighbor.
// ----------------------------------------------------------------------------
module bhl_cell
    import bhl_pkg::*;
(
    input  logic              clk,
    input  logic [IDX_W-1:0]  cell_idx,
    input  bhl_cmd_t          cmd,
    input  logic [DATA_W-1:0] up_val,
    input  logic [DATA_W-1:0] up_rd,
    output logic [DATA_W-1:0] val,
    output logic [DATA_W-1:0] rd
);

    logic [DATA_W-1:0] val_reg;
    logic [DATA_W-1:0] val_next;
    logic [DATA_W-1:0] rd_reg;
    logic [DATA_W-1:0] rd_next;
    logic [CMP_W-1:0]  my_idx;

    assign my_idx = CMP_W'(cell_idx);

    // Select the new entry for this slot
    always_comb
    begin
        val_next = val_reg;
        if (cmd.wr_add && (my_idx == cmd.count))
        begin
            val_next = cmd.add_val;
        end
        if (cmd.wr_swap)
        begin
            if (my_idx == cmd.idx_a)
            begin
                val_next = cmd.val_b;
            end
            else if (my_idx == cmd.idx_b)
            begin
                val_next = cmd.val_a;
            end
        end
        if (cmd.wr_rm && (my_idx >= cmd.idx_a) && ((my_idx + 1'b1) < cmd.count))
        begin
            val_next = up_val;
        end
    end

    // Load or advance the read chain
    always_comb
    begin
        rd_next = rd_reg;
        if (cmd.load)
        begin
            rd_next = val_reg;
        end
        else if (cmd.shift)
        begin
            rd_next = up_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        rd_reg  <= rd_next;
    end

    assign val = val_reg;
    assign rd  = rd_reg;

endmodule

[rtl/core/bhl_ctrl.sv]
// ----------------------------------------------------------------------------
// bhl_ctrl
// Request sequencer: checks each request, scans the read chain for the
// addressed entries, issues the cell update and holds the result.
// ----------------------------------------------------------------------------
module bhl_ctrl
    import bhl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // request channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            req_type,
    input  logic [FLD_W-1:0]      index_a,
    input  logic [FLD_W-1:0]      index_b,
    input  logic [DATA_W-1:0]     entry_value,
    // result channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_W-1:0]     result_value,
    output logic                  hit,
    output logic [CNT_W-1:0]      entry_count,
    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // cell side
    input  logic [DATA_W-1:0]     chain_head,
    output bhl_cmd_t              cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [IDX_W-1:0]  scan_reg;
    logic [IDX_W-1:0]  scan_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CAP_W-1:0]  cap_reg;
    logic              ok_reg;
    logic              ok_next;
    logic [1:0]        req_reg;
    logic [FLD_W-1:0]  ia_reg;
    logic [FLD_W-1:0]  ib_reg;
    logic [DATA_W-1:0] add_reg;
    logic [DATA_W-1:0] a_reg;
    logic [DATA_W-1:0] b_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] res_reg;
    logic              hit_reg;
    logic [CNT_W-1:0]  cnt_out_reg;

    logic              accept;
    logic              retire;
    logic              cfg_wr;
    logic [CMP_W-1:0]  cnt_c;
    logic [CMP_W-1:0]  ia_c;
    logic [CMP_W-1:0]  ib_c;
    logic [CMP_W-1:0]  scan_c;

    assign accept = in_valid && in_ready;
    assign retire = (state_reg == S_WRITE) && (!out_valid_reg || out_ready);
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

    assign cnt_c  = CMP_W'(count_reg);
    assign ia_c   = CMP_W'(index_a);
    assign ib_c   = CMP_W'(index_b);
    assign scan_c = CMP_W'(scan_reg);

    // Check the request against the current count and capacity
    always_comb
    begin
        case (req_type)
            REQ_ADD:    ok_next = (cnt_c < CMP_W'(cap_reg)) && (cnt_c < CMP_W'(DEPTH));
            REQ_SWAP:   ok_next = (ia_c < cnt_c) && (ib_c < cnt_c);
            REQ_REMOVE: ok_next = (ia_c < cnt_c);
            REQ_GET:    ok_next = (ia_c < cnt_c);
            default:    ok_next = 1'b0;
        endcase
    end

    // Sequence idle, scan and write
    always_comb
    begin
        state_next = state_reg;
        scan_next  = scan_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    scan_next  = '0;
                    state_next = (ok_next && (req_type != REQ_ADD)) ? S_SCAN : S_WRITE;
                end
            end
            S_SCAN:
            begin
                if (scan_reg == IDX_W'(DEPTH - 1))
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_WRITE:
            begin
                if (retire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Count after the request
    always_comb
    begin
        count_next = count_reg;
        if (ok_reg && (req_reg == REQ_ADD))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ok_reg && (req_reg == REQ_REMOVE))
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Drive the cell command
    always_comb
    begin
        cmd         = '0;
        cmd.load    = accept;
        cmd.shift   = (state_reg == S_SCAN);
        cmd.wr_add  = retire && ok_reg && (req_reg == REQ_ADD);
        cmd.wr_swap = retire && ok_reg && (req_reg == REQ_SWAP);
        cmd.wr_rm   = retire && ok_reg && (req_reg == REQ_REMOVE);
        cmd.idx_a   = CMP_W'(ia_reg);
        cmd.idx_b   = CMP_W'(ib_reg);
        cmd.count   = cnt_c;
        cmd.val_a   = a_reg;
        cmd.val_b   = b_reg;
        cmd.add_val = add_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_reg      <= '0;
            count_reg     <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            scan_reg  <= scan_next;
            if (cfg_wr)
            begin
                cap_reg <= pwdata[CAP_W-1:0];
            end
            if (retire)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request, capture and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_type;
            ia_reg  <= index_a;
            ib_reg  <= index_b;
            add_reg <= entry_value;
            ok_reg  <= ok_next;
        end
        if ((state_reg == S_SCAN) && (scan_c == CMP_W'(ia_reg)))
        begin
            a_reg <= chain_head;
        end
        if ((state_reg == S_SCAN) && (scan_c == CMP_W'(ib_reg)))
        begin
            b_reg <= chain_head;
        end
        if (retire)
        begin
            res_reg     <= (ok_reg && (req_reg inside {REQ_GET, REQ_REMOVE}))
                           ? a_reg : '0;
            hit_reg     <= ok_reg;
            cnt_out_reg <= count_next;
        end
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign result_value = res_reg;
    assign hit          = hit_reg;
    assign entry_count  = cnt_out_reg;
    assign prdata       = (paddr[2] == REG_CAPACITY) ? APB_DATA_W'(cap_reg) : '0;
    assign pready       = 1'b1;

endmodule

[rtl/core/bounded_handle_list_unit.sv]
// ----------------------------------------------------------------------------
// bounded_handle_list_unit
// Ordered list of up to DEPTH 64-bit handles held in a row of cells, with
// add_last, swap, remove and get requests.
// ----------------------------------------------------------------------------
//  channel   | handshake                   | payload
//  ----------+-----------------------------+------------------------------------
//  request   | in_valid / in_ready         | req_type, index_a, index_b,
//            |                             | entry_value
//  result    | out_valid / out_ready       | result_value, hit, entry_count
//  registers | psel, penable, pwrite,      | paddr, pwdata, prdata
//            | pready                      | (capacity_limit at byte 0)
//
//  A request that reads the list (passing swap, remove, get) walks the read
//  chain through all DEPTH cells toward cell 0, one per cycle.
//  add_last and any failing request skip the scan and go straight to write.
//  One request is in flight at a time; a held result does not block the
//  next request, which stalls only in its write cycle until the result
//  register is free.
//  Reset clears the count and restores capacity 16; entry contents are not
//  cleared.
// ----------------------------------------------------------------------------
module bounded_handle_list_unit
    import bhl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            req_type,
    input  logic [FLD_W-1:0]      index_a,
    input  logic [FLD_W-1:0]      index_b,
    input  logic [DATA_W-1:0]     entry_value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_W-1:0]     result_value,
    output logic                  hit,
    output logic [CNT_W-1:0]      entry_count,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    bhl_cmd_t          cmd;
    logic [DATA_W-1:0] cell_val [DEPTH];
    logic [DATA_W-1:0] cell_rd  [DEPTH];

    // Sequence requests
    bhl_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .index_a      (index_a),
        .index_b      (index_b),
        .entry_value  (entry_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value),
        .hit          (hit),
        .entry_count  (entry_count),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .chain_head   (cell_rd[0]),
        .cmd          (cmd)
    );

    // Build the row of cells, each fed by its upper neighbor
    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        logic [DATA_W-1:0] up_val;
        logic [DATA_W-1:0] up_rd;

        if (k == DEPTH - 1)
        begin : g_last
            assign up_val = '0;
            assign up_rd  = '0;
        end
        else
        begin : g_mid
            assign up_val = cell_val[k + 1];
            assign up_rd  = cell_rd[k + 1];
        end

        bhl_cell u_cell (
            .clk      (clk),
            .cell_idx (IDX_W'(k)),
            .cmd      (cmd),
            .up_val   (up_val),
            .up_rd    (up_rd),
            .val      (cell_val[k]),
            .rd       (cell_rd[k])
        );
    end

endmodule
